// ----- rtl/core/ppti_pkg.sv -----
// Shared types, constants and helpers of the planar pose twist integrator.
`default_nettype none

package ppti_pkg;

    localparam int DEF_CORDIC_STEPS   = 16;
    localparam int DEF_POSITION_WIDTH = 32;

    localparam int ANG_W  = 16;
    localparam int STEP_W = 24;
    localparam int OUT_W  = 32;
    localparam int THR_W  = 8;
    localparam int CFG_AW = 4;
    localparam int CFG_DW = 32;

    localparam int CW      = 34;  // CORDIC and multiplier operand width, Q2.30 plus guard
    localparam int ACC_W   = 64;
    localparam int DNUM_W  = 41;  // scaled dividend and quotient width
    localparam int CNT_W   = 6;
    localparam int ATAN_IW = 5;

    localparam int PI_Q = 25736;

    localparam logic signed [17:0]   PI_Q18     = 18'sd25736;
    localparam logic signed [17:0]   TWO_PI_Q18 = 18'sd51472;
    localparam logic signed [15:0]   PI_Q16     = 16'sd25736;
    localparam logic signed [15:0]   HALF_PI_Q16 = 16'sd12868;
    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [CW-1:0] ONE_Q30     = 34'sd1073741824;
    localparam logic signed [ACC_W-1:0] HALF_Q30 = 64'sd536870912;

    localparam logic [1:0] REG_START_X   = 2'd0;
    localparam logic [1:0] REG_START_Y   = 2'd1;
    localparam logic [1:0] REG_START_HDG = 2'd2;
    localparam logic [1:0] REG_THRESHOLD = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CSET,
        S_CORD,
        S_CEND,
        S_MUL0,
        S_MUL1,
        S_ADD,
        S_POST,
        S_DIV,
        S_DEND,
        S_POS,
        S_DONE
    } t_state;

    // Which two-product sum the multiplier is working on.
    typedef enum logic [1:0] {
        J_NX,
        J_NY,
        J_WX,
        J_WY
    } t_job;

    // atan(2^-i) in Q2.30
    function automatic logic [29:0] atan_q30(input logic [ATAN_IW-1:0] idx);
        logic [29:0] v;
        case (idx)
            5'd0:    v = 30'd843314857;
            5'd1:    v = 30'd497837829;
            5'd2:    v = 30'd263043837;
            5'd3:    v = 30'd133525159;
            5'd4:    v = 30'd67021687;
            5'd5:    v = 30'd33543516;
            5'd6:    v = 30'd16775851;
            5'd7:    v = 30'd8388437;
            5'd8:    v = 30'd4194283;
            5'd9:    v = 30'd2097149;
            5'd10:   v = 30'd1048576;
            5'd11:   v = 30'd524288;
            5'd12:   v = 30'd262144;
            5'd13:   v = 30'd131072;
            5'd14:   v = 30'd65536;
            5'd15:   v = 30'd32768;
            5'd16:   v = 30'd16384;
            5'd17:   v = 30'd8192;
            5'd18:   v = 30'd4096;
            5'd19:   v = 30'd2048;
            5'd20:   v = 30'd1024;
            5'd21:   v = 30'd512;
            5'd22:   v = 30'd256;
            5'd23:   v = 30'd128;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

    // Bring an angle sum into (-pi, pi]; one correction covers every input used here.
    function automatic logic signed [15:0] wrap_ang(input logic signed [17:0] a);
        logic signed [17:0] r;
        r = a;
        if (a > PI_Q18) begin
            r = a - TWO_PI_Q18;
        end else if (a <= -PI_Q18) begin
            r = a + TWO_PI_Q18;
        end
        return r[15:0];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/planar_pose_twist_integrator.sv -----
// Planar pose integrator: SE(2) twist steps and pose reloads, one shared arithmetic datapath.
//
//  channel | direction | handshake                     | beat
//  --------+-----------+-------------------------------+-------------------------------------
//  input   | in        | i_in_valid / o_in_stall       | kind, turn, forward and side step
//  output  | out       | o_out_valid / i_out_stall     | pose x, pose y, pose heading
//  config  | in        | APB psel/penable/pwrite/pready| start x, start y, start heading, thr
//
//  A reload beat goes through S_DONE to the output register. A straight twist runs one
//  CORDIC pass on the heading and the rotation; an arc twist first runs a CORDIC pass on
//  the turn and two bit-serial divisions, then the heading pass and the rotation.
//  The input stalls from acceptance until the result is loaded into the output register;
//  a full output register that is stalled holds the finished pose back.
//  Reset (synchronous, active low) clears the pose, the registers and all control.
`default_nettype none

module planar_pose_twist_integrator #(
    parameter int CORDIC_STEPS   = ppti_pkg::DEF_CORDIC_STEPS,
    parameter int POSITION_WIDTH = ppti_pkg::DEF_POSITION_WIDTH
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic                                  i_kind,
    input  logic signed [ppti_pkg::ANG_W-1:0]     i_turn_step,
    input  logic signed [ppti_pkg::STEP_W-1:0]    i_forward_step,
    input  logic signed [ppti_pkg::STEP_W-1:0]    i_side_step,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [ppti_pkg::OUT_W-1:0]     o_pose_x,
    output logic signed [ppti_pkg::OUT_W-1:0]     o_pose_y,
    output logic signed [ppti_pkg::ANG_W-1:0]     o_pose_heading,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [ppti_pkg::CFG_AW-1:0]           paddr,
    input  logic [ppti_pkg::CFG_DW-1:0]           pwdata,
    output logic [ppti_pkg::CFG_DW-1:0]           prdata,
    output logic                                  pready
);
    import ppti_pkg::*;

    localparam int PW = POSITION_WIDTH;
    localparam logic signed [ACC_W-1:0] POS_HI = (64'sd1 <<< (PW - 1)) - 64'sd1;
    localparam logic signed [ACC_W-1:0] POS_LO = -POS_HI - 64'sd1;
    localparam logic [CNT_W-1:0] CORD_LAST = CNT_W'(CORDIC_STEPS - 1);
    localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(DNUM_W - 1);

    function automatic logic signed [PW-1:0] sat_pos(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] r;
        r = v;
        if (v > POS_HI) begin
            r = POS_HI;
        end else if (v < POS_LO) begin
            r = POS_LO;
        end
        return r[PW-1:0];
    endfunction

    // configuration registers
    logic signed [31:0]     r_cfg_x, n_cfg_x;
    logic signed [31:0]     r_cfg_y, n_cfg_y;
    logic signed [ANG_W-1:0] r_cfg_h, n_cfg_h;
    logic [THR_W-1:0]       r_cfg_thr, n_cfg_thr;

    // control
    t_state                 r_state, n_state;
    t_job                   r_job, n_job;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic                   r_csel, n_csel;   // 0: CORDIC on the turn, 1: on the heading
    logic                   r_cneg, n_cneg;
    logic                   r_qneg, n_qneg;
    logic                   r_out_valid, n_out_valid;

    // pose state
    logic signed [PW-1:0]    r_pos_x, n_pos_x;
    logic signed [PW-1:0]    r_pos_y, n_pos_y;
    logic signed [ANG_W-1:0] r_heading, n_heading;

    // item and datapath
    logic signed [ANG_W-1:0]  r_t, n_t;
    logic signed [STEP_W-1:0] r_f, n_f;
    logic signed [STEP_W-1:0] r_s, n_s;
    logic signed [CW-1:0]     r_cx, n_cx, r_cy, n_cy, r_cz, n_cz;
    logic signed [CW-1:0]     r_sn, n_sn, r_cs, n_cs;
    logic signed [ACC_W-1:0]  r_prod, n_prod, r_acc, n_acc;
    logic signed [CW-1:0]     r_wx, n_wx, r_wy, n_wy;
    logic signed [31:0]       r_dx, n_dx, r_dy, n_dy;
    logic [DNUM_W-1:0]        r_dnum, n_dnum;
    logic [15:0]              r_rem, n_rem;
    logic signed [OUT_W-1:0]  r_out_x, n_out_x, r_out_y, n_out_y;
    logic signed [ANG_W-1:0]  r_out_h, n_out_h;

    // combinational helpers
    logic                     in_take;
    logic                     out_free;
    logic [15:0]              in_abs, t_abs;
    logic signed [ANG_W-1:0]  c_wr, c_fold;
    logic                     c_neg;
    logic [ATAN_IW-1:0]       c_idx;
    logic signed [CW-1:0]     c_xs, c_ys, c_at;
    logic signed [CW-1:0]     mul_a, mul_b;
    logic signed [67:0]       mul_p;
    logic signed [CW-1:0]     tcm1, omtc;
    logic [ACC_W-1:0]         acc_abs, dsum;
    logic signed [ACC_W-1:0]  rsum;
    logic [16:0]              d_shift, d_div;
    logic                     d_ge;
    logic signed [DNUM_W:0]   q_sgn;
    logic signed [ACC_W-1:0]  ext_x, ext_y;

    assign pready      = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_pose_x    = r_out_x;
    assign o_pose_y    = r_out_y;
    assign o_pose_heading = r_out_h;

    assign in_take  = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;

    // register reads
    always_comb begin
        unique case (paddr[3:2])
            REG_START_X:   prdata = r_cfg_x;
            REG_START_Y:   prdata = r_cfg_y;
            REG_START_HDG: prdata = CFG_DW'(r_cfg_h);
            REG_THRESHOLD: prdata = {{(CFG_DW - THR_W){1'b0}}, r_cfg_thr};
        endcase
    end

    // magnitudes of the incoming and the held turn
    assign in_abs = i_turn_step[ANG_W-1] ? (~i_turn_step + 16'd1) : i_turn_step;
    assign t_abs  = r_t[ANG_W-1] ? (~r_t + 16'd1) : r_t;

    // CORDIC angle preparation: wrap, then fold into [-pi/2, pi/2]
    always_comb begin
        c_wr   = wrap_ang(18'(r_csel ? r_heading : r_t));
        c_fold = c_wr;
        c_neg  = 1'b0;
        if (c_wr > HALF_PI_Q16) begin
            c_fold = c_wr - PI_Q16;
            c_neg  = 1'b1;
        end else if (c_wr < -HALF_PI_Q16) begin
            c_fold = c_wr + PI_Q16;
            c_neg  = 1'b1;
        end
    end

    // shared CORDIC step
    assign c_idx = r_cnt[ATAN_IW-1:0];
    assign c_xs  = r_cx >>> c_idx;
    assign c_ys  = r_cy >>> c_idx;
    assign c_at  = $signed({4'b0000, atan_q30(c_idx)});

    // shared multiplier operand select
    assign tcm1 = r_cs - ONE_Q30;
    assign omtc = ONE_Q30 - r_cs;

    always_comb begin
        mul_a = r_sn;
        mul_b = CW'(r_f);
        if (r_state == S_MUL0) begin
            case (r_job)
                J_NX: begin mul_a = CW'(r_f); mul_b = r_sn;      end
                J_NY: begin mul_a = CW'(r_s); mul_b = r_sn;      end
                J_WX: begin mul_a = r_cs;     mul_b = CW'(r_dx); end
                J_WY: begin mul_a = r_sn;     mul_b = CW'(r_dx); end
                default: ;
            endcase
        end else begin
            case (r_job)
                J_NX: begin mul_a = CW'(r_s); mul_b = tcm1;      end
                J_NY: begin mul_a = CW'(r_f); mul_b = omtc;      end
                J_WX: begin mul_a = r_sn;     mul_b = CW'(r_dy); end
                J_WY: begin mul_a = r_cs;     mul_b = CW'(r_dy); end
                default: ;
            endcase
        end
    end

    assign mul_p = mul_a * mul_b;

    // divider setup and step
    assign acc_abs = r_acc[ACC_W-1] ? (~r_acc + 64'd1) : r_acc;
    assign dsum    = acc_abs + {32'd0, t_abs, 16'd0};
    assign rsum    = r_acc + HALF_Q30;
    assign d_shift = {r_rem, r_dnum[DNUM_W-1]};
    assign d_div   = {1'b0, t_abs};
    assign d_ge    = (d_shift >= d_div);
    assign q_sgn   = r_qneg ? -$signed({1'b0, r_dnum}) : $signed({1'b0, r_dnum});

    assign ext_x = ACC_W'(r_pos_x);
    assign ext_y = ACC_W'(r_pos_y);

    // sequencer and datapath next state
    always_comb begin
        n_state = r_state;
        n_job   = r_job;
        n_cnt   = r_cnt;
        n_csel  = r_csel;
        n_cneg  = r_cneg;
        n_qneg  = r_qneg;
        n_pos_x = r_pos_x;
        n_pos_y = r_pos_y;
        n_heading = r_heading;
        n_t     = r_t;
        n_f     = r_f;
        n_s     = r_s;
        n_cx    = r_cx;
        n_cy    = r_cy;
        n_cz    = r_cz;
        n_sn    = r_sn;
        n_cs    = r_cs;
        n_prod  = r_prod;
        n_acc   = r_acc;
        n_wx    = r_wx;
        n_wy    = r_wy;
        n_dx    = r_dx;
        n_dy    = r_dy;
        n_dnum  = r_dnum;
        n_rem   = r_rem;
        n_out_x = r_out_x;
        n_out_y = r_out_y;
        n_out_h = r_out_h;
        // drop the output beat once it is taken
        n_out_valid = r_out_valid && i_out_stall;

        n_cfg_x   = r_cfg_x;
        n_cfg_y   = r_cfg_y;
        n_cfg_h   = r_cfg_h;
        n_cfg_thr = r_cfg_thr;
        if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                REG_START_X:   n_cfg_x   = pwdata;
                REG_START_Y:   n_cfg_y   = pwdata;
                REG_START_HDG: n_cfg_h   = pwdata[ANG_W-1:0];
                REG_THRESHOLD: n_cfg_thr = pwdata[THR_W-1:0];
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    n_t = i_turn_step;
                    n_f = i_forward_step;
                    n_s = i_side_step;
                    if (i_kind) begin
                        // reload the start pose
                        n_pos_x   = sat_pos(ACC_W'(r_cfg_x));
                        n_pos_y   = sat_pos(ACC_W'(r_cfg_y));
                        n_heading = wrap_ang(18'(r_cfg_h));
                        n_state   = S_DONE;
                    end else if (in_abs <= {8'd0, r_cfg_thr}) begin
                        // small turn: pure translation, go straight to the heading rotation
                        n_dx    = 32'(i_forward_step);
                        n_dy    = 32'(i_side_step);
                        n_csel  = 1'b1;
                        n_state = S_CSET;
                    end else begin
                        n_csel  = 1'b0;
                        n_state = S_CSET;
                    end
                end
            end
            S_CSET: begin
                n_cx    = CORDIC_GAIN;
                n_cy    = '0;
                n_cz    = CW'(c_fold) <<< 17;
                n_cneg  = c_neg;
                n_cnt   = '0;
                n_state = S_CORD;
            end
            S_CORD: begin
                if (!r_cz[CW-1]) begin
                    n_cx = r_cx - c_ys;
                    n_cy = r_cy + c_xs;
                    n_cz = r_cz - c_at;
                end else begin
                    n_cx = r_cx + c_ys;
                    n_cy = r_cy - c_xs;
                    n_cz = r_cz + c_at;
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CORD_LAST) begin
                    n_state = S_CEND;
                end
            end
            S_CEND: begin
                n_sn    = r_cneg ? -r_cy : r_cy;
                n_cs    = r_cneg ? -r_cx : r_cx;
                n_job   = r_csel ? J_WX : J_NX;
                n_state = S_MUL0;
            end
            S_MUL0: begin
                n_prod  = mul_p[ACC_W-1:0];
                n_state = S_MUL1;
            end
            S_MUL1: begin
                n_acc   = r_prod;
                n_prod  = mul_p[ACC_W-1:0];
                n_state = S_ADD;
            end
            S_ADD: begin
                n_acc   = (r_job == J_WX) ? (r_acc - r_prod) : (r_acc + r_prod);
                n_state = S_POST;
            end
            S_POST: begin
                case (r_job) inside
                    J_NX, J_NY: begin
                        // round to nearest, ties away from zero, by pre-adding half the divisor
                        n_dnum  = dsum[17 +: DNUM_W];
                        n_rem   = '0;
                        n_qneg  = r_acc[ACC_W-1] ^ r_t[ANG_W-1];
                        n_cnt   = '0;
                        n_state = S_DIV;
                    end
                    J_WX: begin
                        n_wx    = rsum[ACC_W-1:30];
                        n_job   = J_WY;
                        n_state = S_MUL0;
                    end
                    default: begin
                        n_wy    = rsum[ACC_W-1:30];
                        n_state = S_POS;
                    end
                endcase
            end
            S_DIV: begin
                // one quotient bit per cycle by restoring division
                n_rem  = d_ge ? 16'(d_shift - d_div) : d_shift[15:0];
                n_dnum = {r_dnum[DNUM_W-2:0], d_ge};
                n_cnt  = r_cnt + 1'b1;
                if (r_cnt == DIV_LAST) begin
                    n_state = S_DEND;
                end
            end
            S_DEND: begin
                if (r_job == J_NX) begin
                    n_dx    = q_sgn[31:0];
                    n_job   = J_NY;
                    n_state = S_MUL0;
                end else begin
                    n_dy    = q_sgn[31:0];
                    n_csel  = 1'b1;
                    n_state = S_CSET;
                end
            end
            S_POS: begin
                n_pos_x   = sat_pos(ext_x + ACC_W'(r_wx));
                n_pos_y   = sat_pos(ext_y + ACC_W'(r_wy));
                n_heading = wrap_ang(18'(r_heading) + 18'(r_t));
                n_state   = S_DONE;
            end
            S_DONE: begin
                // hold the finished pose until the output register frees up
                if (out_free) begin
                    n_out_x     = ext_x[OUT_W-1:0];
                    n_out_y     = ext_y[OUT_W-1:0];
                    n_out_h     = r_heading;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_job       <= J_NX;
            r_cnt       <= '0;
            r_csel      <= 1'b0;
            r_cneg      <= 1'b0;
            r_qneg      <= 1'b0;
            r_out_valid <= 1'b0;
            r_pos_x     <= '0;
            r_pos_y     <= '0;
            r_heading   <= '0;
            r_cfg_x     <= '0;
            r_cfg_y     <= '0;
            r_cfg_h     <= '0;
            r_cfg_thr   <= '0;
        end else begin
            r_state     <= n_state;
            r_job       <= n_job;
            r_cnt       <= n_cnt;
            r_csel      <= n_csel;
            r_cneg      <= n_cneg;
            r_qneg      <= n_qneg;
            r_out_valid <= n_out_valid;
            r_pos_x     <= n_pos_x;
            r_pos_y     <= n_pos_y;
            r_heading   <= n_heading;
            r_cfg_x     <= n_cfg_x;
            r_cfg_y     <= n_cfg_y;
            r_cfg_h     <= n_cfg_h;
            r_cfg_thr   <= n_cfg_thr;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_t     <= n_t;
        r_f     <= n_f;
        r_s     <= n_s;
        r_cx    <= n_cx;
        r_cy    <= n_cy;
        r_cz    <= n_cz;
        r_sn    <= n_sn;
        r_cs    <= n_cs;
        r_prod  <= n_prod;
        r_acc   <= n_acc;
        r_wx    <= n_wx;
        r_wy    <= n_wy;
        r_dx    <= n_dx;
        r_dy    <= n_dy;
        r_dnum  <= n_dnum;
        r_rem   <= n_rem;
        r_out_x <= n_out_x;
        r_out_y <= n_out_y;
        r_out_h <= n_out_h;
    end

`ifndef NO_ASSERTIONS
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after a beat was taken");

    a_heading_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (int'(o_pose_heading) <= PI_Q && int'(o_pose_heading) > -PI_Q))
        else $error("output heading outside (-pi, pi]");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_cnt <= DIV_LAST))
        else $error("divider ran past its last step");

    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && out_free) |=> (o_out_valid && r_state == S_IDLE))
        else $error("finished pose not presented");
`endif

endmodule

`default_nettype wire
